// ----- hdl/boxds_pkg.sv -----
// boxds_pkg: shared widths and register indexes of the box average downscaler
// used by the channel interfaces, the top level and its checker; no dependencies
package boxds_pkg;

  // field widths of the pixel and result words
  localparam int CH_W    = 8;
  localparam int COORD_W = 10;

  // packed column sums: four 16-bit lanes, red lowest
  localparam int LANES   = 4;
  localparam int LANE_W  = 16;
  localparam int SUM_W   = LANES * LANE_W;

  // configuration register widths
  localparam int SRC_DIM_W = 13;
  localparam int OUT_DIM_W = 11;
  localparam int SCALE_W   = 5;
  localparam int AREA_W    = 2 * SCALE_W;

  // source position counters
  localparam int SRC_COL_W = 12;
  localparam int SRC_ROW_W = 14;

  // fixed clamp limits of the source width and output height
  localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_TOP  = 13'd4096;
  localparam logic [OUT_DIM_W-1:0] OUT_HEIGHT_TOP = 11'd1024;

  // serial divider step counter
  localparam int DIV_CNT_W = $clog2(LANE_W);

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_OUT_WIDTH  = 3'd1,
    REG_OUT_HEIGHT = 3'd2,
    REG_SCALE_X    = 3'd3,
    REG_SCALE_Y    = 3'd4
  } reg_idx_e;

endpackage

// ----- hdl/boxds_if.sv -----
// boxds_pix_if and boxds_avg_if: valid/ready channels for source pixels and results
// depends on boxds_pkg for the field widths
interface boxds_pix_if;
  import boxds_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;
  logic [CH_W-1:0]   alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface boxds_avg_if;
  import boxds_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    avg_red;
  logic [CH_W-1:0]    avg_green;
  logic [CH_W-1:0]    avg_blue;
  logic [CH_W-1:0]    avg_alpha;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               frame_end;

  modport source (output valid, output avg_red, output avg_green, output avg_blue,
                  output avg_alpha, output col, output row, output frame_end,
                  input ready);
  modport sink   (input valid, input avg_red, input avg_green, input avg_blue,
                  input avg_alpha, input col, input row, input frame_end,
                  output ready);
endinterface

// ----- hdl/box_average_downscaler_unit.sv -----
// Pixels that complete no block are taken one per cycle unless the modify stage stalls; each
// block-completing pixel holds the shared 16-step serial divider, which takes no new block
// until its last result has moved to the result register. The line store is a synchronous
// single-port-write memory, read on accept and written back from the modify stage, with a
// bypass of the last write. Reset (rst_ni low, asynchronous) sets the configuration
// registers to 1 and the source position to zero; line store contents are left undefined.
module box_average_downscaler_unit #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_SCALE     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [boxds_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [boxds_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [boxds_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  // pixel and result channels
  boxds_pix_if.sink                           pix_in,
  boxds_avg_if.source                         avg_out
);
  import boxds_pkg::*;

  localparam int AddrW   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int OwTopI  = (MAX_OUT_WIDTH < 2047) ? MAX_OUT_WIDTH : 2047;
  localparam int SxTopI  = (MAX_SCALE < 31) ? MAX_SCALE : 31;
  localparam logic [OUT_DIM_W-1:0] OwTop = OUT_DIM_W'(OwTopI);
  localparam logic [SCALE_W-1:0]   SxTop = SCALE_W'(SxTopI);
  localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(LANE_W - 1);

  // configuration registers
  logic [SRC_DIM_W-1:0] src_width_q;
  logic [OUT_DIM_W-1:0] out_width_q, out_height_q;
  logic [SCALE_W-1:0]   scale_x_q, scale_y_q;

  // clamped register values
  logic [SRC_DIM_W-1:0] sw_c;
  logic [OUT_DIM_W-1:0] ow_c, oh_c;
  logic [SCALE_W-1:0]   sx_c, sy_c;

  // source position
  logic [SRC_COL_W-1:0] src_col_q;
  logic [SRC_ROW_W-1:0] src_row_q;
  logic [SCALE_W-1:0]   bx_q, by_q;
  logic [SRC_COL_W-1:0] ox_q;
  logic [SRC_ROW_W-1:0] oy_q;

  logic                 cfg_we, cfg_hit;
  reg_idx_e             cfg_idx;

  logic                 in_ready, in_acc, in_range, col_last, bx_last, by_last;
  logic [SUM_W-1:0]     pix_sum;
  logic [AddrW-1:0]     in_addr;

  // line store and its bypass
  logic [SUM_W-1:0]     mem_q [MAX_OUT_WIDTH];
  logic [SUM_W-1:0]     rd_data_q;
  logic                 wb_valid_q;
  logic [AddrW-1:0]     wb_addr_q;
  logic [SUM_W-1:0]     wb_data_q;

  // read-modify-write stage
  logic                 s1_valid_q, s1_first_q, s1_emit_q, s1_last_q;
  logic [AddrW-1:0]     s1_addr_q;
  logic [SUM_W-1:0]     s1_pix_q;
  logic [COORD_W-1:0]   s1_col_q, s1_row_q;
  logic [SUM_W-1:0]     old_sum, acc;
  logic                 s1_go;

  // serial divider
  logic                 div_run_q, div_hold_q, div_free, div_start, out_load;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [AREA_W-1:0]    div_area_q;
  logic [AREA_W-1:0]    div_rem_q [LANES];
  logic [LANE_W-1:0]    div_quo_q [LANES];
  logic [AREA_W-1:0]    div_rem_d [LANES];
  logic [LANE_W-1:0]    div_quo_d [LANES];
  logic [COORD_W-1:0]   div_col_q, div_row_q;
  logic                 div_last_q;

  // result register
  logic                 out_valid_q;
  logic [CH_W-1:0]      out_avg_q [LANES];
  logic [COORD_W-1:0]   out_col_q, out_row_q;
  logic                 out_last_q;

  // zero reads as one, anything above the range as its top
  always_comb begin
    sw_c = (src_width_q == '0) ? SRC_DIM_W'(1) :
           (src_width_q > SRC_WIDTH_TOP) ? SRC_WIDTH_TOP : src_width_q;
    ow_c = (out_width_q == '0) ? OUT_DIM_W'(1) :
           (out_width_q > OwTop) ? OwTop : out_width_q;
    oh_c = (out_height_q == '0) ? OUT_DIM_W'(1) :
           (out_height_q > OUT_HEIGHT_TOP) ? OUT_HEIGHT_TOP : out_height_q;
    sx_c = (scale_x_q == '0) ? SCALE_W'(1) : (scale_x_q > SxTop) ? SxTop : scale_x_q;
    sy_c = (scale_y_q == '0) ? SCALE_W'(1) : (scale_y_q > SxTop) ? SxTop : scale_y_q;
  end

  // configuration decode and readback
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[REG_IDX_W+1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    cfg_hit = 1'b1;
    prdata  = '0;
    case (cfg_idx)
      REG_SRC_WIDTH:  prdata = CFG_DATA_W'(src_width_q);
      REG_OUT_WIDTH:  prdata = CFG_DATA_W'(out_width_q);
      REG_OUT_HEIGHT: prdata = CFG_DATA_W'(out_height_q);
      REG_SCALE_X:    prdata = CFG_DATA_W'(scale_x_q);
      REG_SCALE_Y:    prdata = CFG_DATA_W'(scale_y_q);
      default:        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_DIM_W'(1);
      out_width_q  <= OUT_DIM_W'(1);
      out_height_q <= OUT_DIM_W'(1);
      scale_x_q    <= SCALE_W'(1);
      scale_y_q    <= SCALE_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SRC_DIM_W-1:0];
        REG_OUT_WIDTH:  out_width_q  <= pwdata[OUT_DIM_W-1:0];
        REG_OUT_HEIGHT: out_height_q <= pwdata[OUT_DIM_W-1:0];
        REG_SCALE_X:    scale_x_q    <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y:    scale_y_q    <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // input side: block position and line store address of the current pixel
  assign in_ready = !s1_valid_q || s1_go;
  assign pix_in.ready = in_ready;
  assign in_acc   = pix_in.valid && in_ready;
  assign col_last = ({1'b0, src_col_q} + SRC_DIM_W'(1)) >= sw_c;
  assign bx_last  = (bx_q == sx_c - SCALE_W'(1));
  assign by_last  = (by_q == sy_c - SCALE_W'(1));
  assign in_range = (ox_q < SRC_COL_W'(ow_c)) && (oy_q < SRC_ROW_W'(oh_c));
  assign in_addr  = AddrW'(ox_q);
  assign pix_sum  = {{(LANE_W-CH_W){1'b0}}, pix_in.alpha, {(LANE_W-CH_W){1'b0}}, pix_in.blue,
                     {(LANE_W-CH_W){1'b0}}, pix_in.green, {(LANE_W-CH_W){1'b0}}, pix_in.red};

  // source position counters, restarted by any register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      bx_q      <= '0;
      by_q      <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
    end else if (cfg_we && cfg_hit) begin
      src_col_q <= '0;
      src_row_q <= '0;
      bx_q      <= '0;
      by_q      <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        src_col_q <= '0;
        bx_q      <= '0;
        ox_q      <= '0;
        src_row_q <= src_row_q + SRC_ROW_W'(1);
        if (src_row_q == '1) begin
          by_q <= '0;
          oy_q <= '0;
        end else if (by_last) begin
          by_q <= '0;
          oy_q <= oy_q + SRC_ROW_W'(1);
        end else begin
          by_q <= by_q + SCALE_W'(1);
        end
      end else begin
        src_col_q <= src_col_q + SRC_COL_W'(1);
        if (bx_last) begin
          bx_q <= '0;
          ox_q <= ox_q + SRC_COL_W'(1);
        end else begin
          bx_q <= bx_q + SCALE_W'(1);
        end
      end
    end
  end

  // line store: read on accept, write back from the modify stage
  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      rd_data_q <= mem_q[in_addr];
    end
    if (s1_go) begin
      mem_q[s1_addr_q] <= acc;
    end
  end

  // last write, forwarded when the stage reads the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else if (s1_go) begin
      wb_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      wb_addr_q <= s1_addr_q;
      wb_data_q <= acc;
    end
  end

  // modify stage: overwrite on the first pixel of a block, else accumulate
  assign old_sum = (wb_valid_q && (wb_addr_q == s1_addr_q)) ? wb_data_q : rd_data_q;
  assign acc     = s1_first_q ? s1_pix_q : old_sum + s1_pix_q;

  assign out_load  = div_hold_q && (!out_valid_q || avg_out.ready);
  assign div_free  = !div_run_q && (!div_hold_q || out_load);
  assign s1_go     = s1_valid_q && (!s1_emit_q || div_free);
  assign div_start = s1_go && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_acc && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      s1_addr_q  <= in_addr;
      s1_pix_q   <= pix_sum;
      s1_first_q <= (bx_q == '0) && (by_q == '0);
      s1_emit_q  <= bx_last && by_last;
      s1_col_q   <= ox_q[COORD_W-1:0];
      s1_row_q   <= oy_q[COORD_W-1:0];
      s1_last_q  <= (ox_q == SRC_COL_W'(ow_c - OUT_DIM_W'(1))) &&
                    (oy_q == SRC_ROW_W'(oh_c - OUT_DIM_W'(1)));
    end
  end

  // one restoring division step per lane and cycle
  always_comb begin
    logic [AREA_W:0] trial;
    logic            ge;
    for (int l = 0; l < LANES; l++) begin
      trial = {div_rem_q[l], div_quo_q[l][LANE_W-1]};
      ge    = trial >= {1'b0, div_area_q};
      div_rem_d[l] = ge ? AREA_W'(trial - {1'b0, div_area_q}) : trial[AREA_W-1:0];
      div_quo_d[l] = {div_quo_q[l][LANE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q  <= 1'b0;
      div_hold_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_start) begin
      div_run_q  <= 1'b1;
      div_hold_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_run_q) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      if (div_cnt_q == DivLast) begin
        div_run_q  <= 1'b0;
        div_hold_q <= 1'b1;
      end
    end else if (out_load) begin
      div_hold_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_area_q <= {{SCALE_W{1'b0}}, sx_c} * {{SCALE_W{1'b0}}, sy_c};
      div_col_q  <= s1_col_q;
      div_row_q  <= s1_row_q;
      div_last_q <= s1_last_q;
      for (int l = 0; l < LANES; l++) begin
        div_rem_q[l] <= '0;
        div_quo_q[l] <= acc[l*LANE_W +: LANE_W];
      end
    end else if (div_run_q) begin
      for (int l = 0; l < LANES; l++) begin
        div_rem_q[l] <= div_rem_d[l];
        div_quo_q[l] <= div_quo_d[l];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (avg_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int l = 0; l < LANES; l++) begin
        out_avg_q[l] <= div_quo_q[l][CH_W-1:0];
      end
      out_col_q  <= div_col_q;
      out_row_q  <= div_row_q;
      out_last_q <= div_last_q;
    end
  end

  assign avg_out.valid     = out_valid_q;
  assign avg_out.avg_red   = out_avg_q[0];
  assign avg_out.avg_green = out_avg_q[1];
  assign avg_out.avg_blue  = out_avg_q[2];
  assign avg_out.avg_alpha = out_avg_q[3];
  assign avg_out.col       = out_col_q;
  assign avg_out.row       = out_row_q;
  assign avg_out.frame_end = out_last_q;

endmodule

// ----- hdl/boxds_checker.sv -----
// boxds_checker: port-level assertions on the box average downscaler, bound to its top level
// depends on boxds_pkg and on box_average_downscaler_unit
module boxds_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   psel_i,
  input logic                                   penable_i,
  input logic                                   pwrite_i,
  input logic [boxds_pkg::CFG_ADDR_W-1:0]       paddr_i,
  input logic [boxds_pkg::CFG_DATA_W-1:0]       pwdata_i,
  input logic [boxds_pkg::CFG_DATA_W-1:0]       prdata_i,
  input logic                                   in_valid_i,
  input logic                                   in_ready_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic [boxds_pkg::CH_W-1:0]             out_red_i,
  input logic [boxds_pkg::COORD_W-1:0]          out_col_i,
  input logic [boxds_pkg::COORD_W-1:0]          out_row_i,
  input logic                                   out_last_i
);
  import boxds_pkg::*;

  localparam int CntW = 48;

  logic            in_acc, out_acc, cfg_wr;
  logic [CntW-1:0] in_cnt_q, out_cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cfg_wr  = psel_i && penable_i && pwrite_i;

  // bits a register keeps of a written word
  function automatic logic [CFG_DATA_W-1:0] reg_mask(logic [CFG_ADDR_W-1:0] addr);
    logic [CFG_DATA_W-1:0] m;
    m = '0;
    case (reg_idx_e'(addr[REG_IDX_W+1:2]))
      REG_SRC_WIDTH:  m = CFG_DATA_W'({SRC_DIM_W{1'b1}});
      REG_OUT_WIDTH:  m = CFG_DATA_W'({OUT_DIM_W{1'b1}});
      REG_OUT_HEIGHT: m = CFG_DATA_W'({OUT_DIM_W{1'b1}});
      REG_SCALE_X:    m = CFG_DATA_W'({SCALE_W{1'b1}});
      REG_SCALE_Y:    m = CFG_DATA_W'({SCALE_W{1'b1}});
      default:        m = '0;
    endcase
    return m;
  endfunction

  // words taken in and given out since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (in_acc) begin
        in_cnt_q <= in_cnt_q + CntW'(1);
      end
      if (out_acc) begin
        out_cnt_q <= out_cnt_q + CntW'(1);
      end
    end
  end

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its red average, column, row and frame end flag
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_red_i) && $stable(out_col_i) && $stable(out_row_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  // every result word is caused by a pixel taken earlier
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> out_cnt_q < in_cnt_q)
    else $error("more result words than pixels taken");

  // a register reads back what was written to it
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr ##1 (psel_i && !pwrite_i && paddr_i == $past(paddr_i)) |->
      prdata_i == ($past(pwdata_i) & reg_mask(paddr_i)))
    else $error("register readback mismatch");

endmodule

bind box_average_downscaler_unit boxds_checker u_boxds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata),
  .in_valid_i  (pix_in.valid),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (avg_out.valid),
  .out_ready_i (avg_out.ready),
  .out_red_i   (avg_out.avg_red),
  .out_col_i   (avg_out.col),
  .out_row_i   (avg_out.row),
  .out_last_i  (avg_out.frame_end)
);
